/* rtl/sia_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer ALU package
// Operation codes, status codes and shared types.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int DataWidthDefault = 32;
  localparam int OpWidth = 5;
  localparam int StatusWidth = 2;

  localparam logic [OpWidth-1:0] OP_ADD  = 5'd0;
  localparam logic [OpWidth-1:0] OP_SUB  = 5'd1;
  localparam logic [OpWidth-1:0] OP_MUL  = 5'd2;
  localparam logic [OpWidth-1:0] OP_DIV  = 5'd3;
  localparam logic [OpWidth-1:0] OP_SHR  = 5'd4;
  localparam logic [OpWidth-1:0] OP_SHL  = 5'd5;
  localparam logic [OpWidth-1:0] OP_GT   = 5'd6;
  localparam logic [OpWidth-1:0] OP_LT   = 5'd7;
  localparam logic [OpWidth-1:0] OP_LE   = 5'd8;
  localparam logic [OpWidth-1:0] OP_GE   = 5'd9;
  localparam logic [OpWidth-1:0] OP_EQ   = 5'd10;
  localparam logic [OpWidth-1:0] OP_NE   = 5'd11;
  localparam logic [OpWidth-1:0] OP_AND  = 5'd12;
  localparam logic [OpWidth-1:0] OP_XOR  = 5'd13;
  localparam logic [OpWidth-1:0] OP_OR   = 5'd14;
  localparam logic [OpWidth-1:0] OP_LAND = 5'd15;
  localparam logic [OpWidth-1:0] OP_LOR  = 5'd16;
  localparam logic [OpWidth-1:0] OP_LNOT = 5'd17;
  localparam logic [OpWidth-1:0] OP_INV  = 5'd18;

  localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] ST_DIV0  = 2'd1;
  localparam logic [StatusWidth-1:0] ST_BADOP = 2'd2;

  // Execution unit chosen by the front end.
  localparam logic [1:0] UNIT_SIMPLE = 2'd0;
  localparam logic [1:0] UNIT_MUL    = 2'd1;
  localparam logic [1:0] UNIT_DIV    = 2'd2;

  typedef struct packed {
    logic [1:0]             unit;
    logic [StatusWidth-1:0] status;
  } cls_t;

endpackage

/* rtl/sia_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer ALU front end
// Accepts a word, decodes it and pushes it into a small issue queue.
// ----------------------------------------------------------------------------
module sia_front #(
  parameter int DATA_WIDTH = sia_pkg::DataWidthDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sia_pkg::OpWidth-1:0]  operation,
  input  logic signed [DATA_WIDTH-1:0] operand_a,
  input  logic signed [DATA_WIDTH-1:0] operand_b,
  output logic                         q_valid,
  input  logic                         q_ready,
  output logic [sia_pkg::OpWidth-1:0]  q_op,
  output logic [DATA_WIDTH-1:0]        q_a,
  output logic [DATA_WIDTH-1:0]        q_b,
  output sia_pkg::cls_t                q_cls
);
  import sia_pkg::*;

  localparam int Depth = 2;

  logic [OpWidth-1:0]    op_mem  [Depth];
  logic [DATA_WIDTH-1:0] a_mem   [Depth];
  logic [DATA_WIDTH-1:0] b_mem   [Depth];
  cls_t                  cls_mem [Depth];
  logic                  wr_ptr, rd_ptr;
  logic [1:0]            count;
  cls_t                  cls;
  logic                  push, pop;

  always_comb begin
    cls.unit = UNIT_SIMPLE;
    cls.status = ST_OK;
    if (operation == OP_MUL) begin
      cls.unit = UNIT_MUL;
    end else if (operation == OP_DIV) begin
      cls.unit = UNIT_DIV;
      if (operand_b == '0) cls.status = ST_DIV0;
    end else if (operation > OP_INV) begin
      cls.status = ST_BADOP;
    end
  end

  assign in_ready = (count != 2'(Depth));
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      op_mem[wr_ptr]  <= operation;
      a_mem[wr_ptr]   <= operand_a;
      b_mem[wr_ptr]   <= operand_b;
      cls_mem[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign q_op  = op_mem[rd_ptr];
  assign q_a   = a_mem[rd_ptr];
  assign q_b   = b_mem[rd_ptr];
  assign q_cls = cls_mem[rd_ptr];

endmodule

/* rtl/sia_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer ALU back end
// Pipeline with a two-stage multiplier and a radix-2 divider pipeline
// of DATA_WIDTH stages. All words travel the full depth so they stay in order.
// ----------------------------------------------------------------------------
module sia_back #(
  parameter int DATA_WIDTH = sia_pkg::DataWidthDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  logic [sia_pkg::OpWidth-1:0]       q_op,
  input  logic [DATA_WIDTH-1:0]             q_a,
  input  logic [DATA_WIDTH-1:0]             q_b,
  input  sia_pkg::cls_t                     q_cls,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [DATA_WIDTH-1:0]      result,
  output logic [sia_pkg::StatusWidth-1:0]   status
);
  import sia_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam int Stages = W + 2;
  localparam int HalfW = (W + 1) / 2;

  // Pipeline advances whenever the output register can take a word.
  logic adv;
  assign adv = !out_valid || out_ready;
  assign q_ready = adv;

  // Stage 0: simple ops and operand preparation.
  logic [W-1:0] simple_r;
  logic [4:0]   sh;
  logic signed [W-1:0] sa, sb;
  logic [W-1:0] mag_a, mag_b;

  assign sa = q_a;
  assign sb = q_b;
  assign sh = q_b[4:0];
  assign mag_a = q_a[W-1] ? (~q_a + 1'b1) : q_a;
  assign mag_b = q_b[W-1] ? (~q_b + 1'b1) : q_b;

  always_comb begin
    simple_r = '0;
    case (q_op)
      OP_ADD:  simple_r = q_a + q_b;
      OP_SUB:  simple_r = q_a - q_b;
      OP_SHR:  simple_r = (32'(sh) >= W) ? {W{q_a[W-1]}} : W'(sa >>> sh);
      OP_SHL:  simple_r = (32'(sh) >= W) ? '0 : W'(q_a << sh);
      OP_GT:   simple_r = W'(sa > sb);
      OP_LT:   simple_r = W'(sa < sb);
      OP_LE:   simple_r = W'(sa <= sb);
      OP_GE:   simple_r = W'(sa >= sb);
      OP_EQ:   simple_r = W'(q_a == q_b);
      OP_NE:   simple_r = W'(q_a != q_b);
      OP_AND:  simple_r = q_a & q_b;
      OP_XOR:  simple_r = q_a ^ q_b;
      OP_OR:   simple_r = q_a | q_b;
      OP_LAND: simple_r = W'((q_a != '0) && (q_b != '0));
      OP_LOR:  simple_r = W'((q_a != '0) || (q_b != '0));
      OP_LNOT: simple_r = W'(q_a == '0);
      OP_INV:  simple_r = ~q_a;
      default: simple_r = '0;
    endcase
  end

  // Per-stage registers.
  logic [Stages-1:0] v;
  cls_t         cls_s  [Stages];
  logic [W-1:0] res_s  [Stages];
  logic         neg_s  [Stages];
  logic [W-1:0] rem_s  [Stages];
  logic [W-1:0] quo_s  [Stages];
  logic [W-1:0] dvs_s  [Stages];
  // Multiplier partial products (stage 0 -> 1).
  logic [W-1:0] pp_lo, pp_x1, pp_x2;

  always_ff @(posedge clk) begin
    if (adv) begin
      cls_s[0] <= q_cls;
      res_s[0] <= simple_r;
      neg_s[0] <= q_a[W-1] ^ q_b[W-1];
      rem_s[0] <= '0;
      quo_s[0] <= mag_a;
      dvs_s[0] <= mag_b;
      pp_lo <= W'(W'(q_a[HalfW-1:0]) * W'(q_b[HalfW-1:0]));
      pp_x1 <= W'(W'(q_a[W-1:HalfW]) * W'(q_b[HalfW-1:0]));
      pp_x2 <= W'(W'(q_a[HalfW-1:0]) * W'(q_b[W-1:HalfW]));
    end
  end

  // Stage 1: finish the multiply; low W bits only are needed.
  always_ff @(posedge clk) begin
    if (adv) begin
      cls_s[1] <= cls_s[0];
      res_s[1] <= (cls_s[0].unit == UNIT_MUL)
                  ? W'(pp_lo + W'({pp_x1 + pp_x2, {HalfW{1'b0}}}))
                  : res_s[0];
      neg_s[1] <= neg_s[0];
      rem_s[1] <= rem_s[0];
      quo_s[1] <= quo_s[0];
      dvs_s[1] <= dvs_s[0];
    end
  end

  // Stages 2..W+1: one restoring divide step each.
  for (genvar g = 2; g < Stages; g++) begin : g_div
    logic [W:0] trial;
    logic [W:0] shifted;
    assign shifted = {rem_s[g-1], quo_s[g-1][W-1]};
    assign trial = shifted - {1'b0, dvs_s[g-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        cls_s[g] <= cls_s[g-1];
        res_s[g] <= res_s[g-1];
        neg_s[g] <= neg_s[g-1];
        dvs_s[g] <= dvs_s[g-1];
        if (!trial[W]) begin
          rem_s[g] <= trial[W-1:0];
          quo_s[g] <= {quo_s[g-1][W-2:0], 1'b1};
        end else begin
          rem_s[g] <= shifted[W-1:0];
          quo_s[g] <= {quo_s[g-1][W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v <= {v[Stages-2:0], q_valid};
      out_valid <= v[Stages-1];
    end
  end

  logic [W-1:0] fin;
  always_comb begin
    fin = res_s[Stages-1];
    if (cls_s[Stages-1].unit == UNIT_DIV) begin
      fin = neg_s[Stages-1] ? (~quo_s[Stages-1] + 1'b1) : quo_s[Stages-1];
    end
    if (cls_s[Stages-1].status != ST_OK) fin = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= fin;
      status <= cls_s[Stages-1].status;
    end
  end

endmodule

/* rtl/signed_integer_alu_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer ALU
// Channel   Handshake            Payload
// input     in_valid/in_ready    operation, operand_a, operand_b
// output    out_valid/out_ready  result, status
// One word is accepted per cycle unless the output stalls. Every operation takes
// the full depth of the one-bit-per-stage divider pipeline; words leave in order.
// Reset clears all valid flags. A stalled output freezes the back-end pipeline;
// the two-entry issue queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
module signed_integer_alu_top #(
  parameter int DATA_WIDTH = sia_pkg::DataWidthDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sia_pkg::OpWidth-1:0]     operation,
  input  logic signed [DATA_WIDTH-1:0]    operand_a,
  input  logic signed [DATA_WIDTH-1:0]    operand_b,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [DATA_WIDTH-1:0]    result,
  output logic [sia_pkg::StatusWidth-1:0] status
);
  import sia_pkg::*;

  logic                  q_valid, q_ready;
  logic [OpWidth-1:0]    q_op;
  logic [DATA_WIDTH-1:0] q_a, q_b;
  cls_t                  q_cls;

  sia_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .operation, .operand_a, .operand_b,
    .q_valid, .q_ready, .q_op, .q_a, .q_b, .q_cls
  );

  sia_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_op, .q_a, .q_b, .q_cls,
    .out_valid, .out_ready, .result, .status
  );

endmodule
